### sv/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the transfer sender RTL.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

### sv/cts_pkg.sv
// -----------------------------------------------------------------------------
// cts_pkg
// Types and constants for the chunked transfer sender.
// -----------------------------------------------------------------------------
`default_nettype none

package cts_pkg;

  localparam int CHUNK_NUM_W   = 21;
  localparam int CHUNK_BYTES_W = 13;
  localparam int TIMER_W       = 16;
  localparam int FILE_LEN_W    = 32;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;

  localparam int CHUNK_SHIFT   = 12;
  localparam int OFFSET_W      = CHUNK_NUM_W + CHUNK_SHIFT;
  localparam logic [CHUNK_BYTES_W-1:0] CHUNK_BYTES = CHUNK_BYTES_W'(1 << CHUNK_SHIFT);

  localparam logic [FILE_LEN_W-1:0] FILE_LEN_RST = 32'd1;
  localparam logic [TIMER_W-1:0]    TIMEOUT_RST  = 16'd1000;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_SENT  = 2'd1;
  localparam logic [1:0] REQ_REPLY = 2'd2;

  localparam logic REPLY_RESTART = 1'b0;
  localparam logic REPLY_BLOB    = 1'b1;

  localparam logic [1:0] SEND_NONE    = 2'd0;
  localparam logic [1:0] SEND_RESTART = 2'd1;
  localparam logic [1:0] SEND_BLOB    = 2'd2;

  localparam logic REG_FILE_LEN = 1'b0;
  localparam logic REG_TIMEOUT  = 1'b1;

  typedef struct packed {
    logic [1:0] req_type;
    logic       send_ok;
    logic       reply_kind;
    logic       reply_accepted;
  } req_t;

  typedef struct packed {
    logic [1:0]               send_kind;
    logic [CHUNK_NUM_W-1:0]   chunk_number;
    logic [CHUNK_BYTES_W-1:0] chunk_bytes;
    logic [CHUNK_NUM_W-1:0]   chunk_count;
    logic                     transfer_done;
  } rsp_t;

  typedef struct packed {
    logic [FILE_LEN_W-1:0] file_length;
    logic [TIMER_W-1:0]    timeout_ticks;
  } cfg_t;

endpackage

`default_nettype wire

### sv/cts_cfg.sv
// -----------------------------------------------------------------------------
// cts_cfg
// APB register file: file length and retransmit timeout.
// -----------------------------------------------------------------------------
`default_nettype none

module cts_cfg
  import cts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t regs;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.file_length   <= FILE_LEN_RST;
      regs.timeout_ticks <= TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_FILE_LEN: regs.file_length   <= pwdata;
        REG_TIMEOUT:  regs.timeout_ticks <= pwdata[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FILE_LEN: prdata = regs.file_length;
      REG_TIMEOUT:  prdata = DATA_W'(regs.timeout_ticks);
      default:      prdata = '0;
    endcase
  end

  assign cfg = regs;

endmodule

`default_nettype wire

### sv/cts_engine.sv
// -----------------------------------------------------------------------------
// cts_engine
// Sender state, retransmit timer and result register; one event per step.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cts_engine
  import cts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic step,
  input  req_t req,
  output rsp_t rsp
);

  typedef enum logic [1:0] {
    PH_RST_WAIT,
    PH_RST_SENT,
    PH_BLOB_SENT,
    PH_DONE
  } phase_t;

  phase_t                 phase, phase_next;
  logic [CHUNK_NUM_W-1:0] next_chunk, chunk_next;
  logic [CHUNK_NUM_W-1:0] total_chunks, total_next;
  logic [TIMER_W-1:0]     timer_left, left_next;
  logic                   timer_running, running_next;

  logic [CHUNK_NUM_W-1:0]   chunk_inc;
  logic [CHUNK_NUM_W-1:0]   blob_idx;
  logic [CHUNK_NUM_W-1:0]   total_calc;
  logic [OFFSET_W-1:0]      blob_off;
  logic [OFFSET_W-1:0]      file_ext;
  logic [OFFSET_W-1:0]      remain;
  logic [CHUNK_BYTES_W-1:0] blob_size;
  logic                     do_restart;
  logic                     do_blob;
  rsp_t                     rsp_next;

  assign chunk_inc  = next_chunk + CHUNK_NUM_W'(1);
  assign total_calc = (cfg.file_length == '0) ? '0 :
                      CHUNK_NUM_W'(cfg.file_length >> CHUNK_SHIFT) + CHUNK_NUM_W'(1);

  always_comb begin
    phase_next   = phase;
    chunk_next   = next_chunk;
    total_next   = total_chunks;
    left_next    = timer_left;
    running_next = timer_running;
    blob_idx     = next_chunk;
    do_restart   = 1'b0;
    do_blob      = 1'b0;
    if (phase != PH_DONE) begin
      case (req.req_type)
        REQ_TICK: begin
          if (timer_running) begin
            if (timer_left <= TIMER_W'(1)) begin
              if (phase == PH_BLOB_SENT) begin
                do_blob = 1'b1;
              end else begin
                do_restart = 1'b1;
              end
            end else begin
              left_next = timer_left - TIMER_W'(1);
            end
          end
        end
        REQ_REPLY: begin
          if (phase == PH_RST_SENT && req.reply_kind == REPLY_RESTART) begin
            if (req.reply_accepted) begin
              do_blob = 1'b1;
            end else begin
              phase_next   = PH_RST_WAIT;
              left_next    = cfg.timeout_ticks;
              running_next = 1'b1;
            end
          end else if (phase == PH_BLOB_SENT && req.reply_kind == REPLY_BLOB) begin
            chunk_next = chunk_inc;
            blob_idx   = chunk_inc;
            if (chunk_inc < total_chunks) begin
              do_blob = 1'b1;
            end else begin
              phase_next   = PH_DONE;
              running_next = 1'b0;
              left_next    = '0;
            end
          end
        end
        default: ;
      endcase
    end
    if (do_restart) begin
      total_next   = total_calc;
      phase_next   = PH_RST_SENT;
      left_next    = cfg.timeout_ticks;
      running_next = 1'b1;
    end
    if (do_blob) begin
      phase_next   = PH_BLOB_SENT;
      left_next    = cfg.timeout_ticks;
      running_next = 1'b1;
    end
  end

  assign blob_off  = {blob_idx, CHUNK_SHIFT'(0)};
  assign file_ext  = OFFSET_W'(cfg.file_length);
  assign remain    = (blob_off < file_ext) ? file_ext - blob_off : '0;
  assign blob_size = (remain < OFFSET_W'(CHUNK_BYTES)) ? remain[CHUNK_BYTES_W-1:0] : CHUNK_BYTES;

  always_comb begin
    rsp_next.send_kind     = SEND_NONE;
    rsp_next.chunk_number  = '0;
    rsp_next.chunk_bytes   = '0;
    rsp_next.chunk_count   = total_next;
    rsp_next.transfer_done = (phase_next == PH_DONE);
    if (do_restart) begin
      rsp_next.send_kind = SEND_RESTART;
    end
    if (do_blob) begin
      rsp_next.send_kind    = SEND_BLOB;
      rsp_next.chunk_number = blob_idx;
      rsp_next.chunk_bytes  = blob_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_RST_WAIT;
      next_chunk    <= '0;
      total_chunks  <= '0;
      timer_left    <= '0;
      timer_running <= 1'b1;
    end else if (step) begin
      phase         <= phase_next;
      next_chunk    <= chunk_next;
      total_chunks  <= total_next;
      timer_left    <= left_next;
      timer_running <= running_next;
    end
    if (step) begin
      rsp <= rsp_next;
    end
  end

  `ASSERT_PROP(a_done_sticky, clk, rst, (phase == PH_DONE) |=> (phase == PH_DONE), "left done")
  `ASSERT_NEVER(a_done_timer, clk, rst, (phase == PH_DONE) && timer_running, "timer runs in done")
  `ASSERT_PROP(a_done_silent, clk, rst, (step && phase == PH_DONE) |=> (rsp.send_kind == SEND_NONE), "send after done")
  `ASSERT_PROP(a_done_flag, clk, rst, step |=> (rsp.transfer_done == (phase == PH_DONE)), "done flag mismatch")

endmodule

`default_nettype wire

### sv/chunked_transfer_sender_fsm.sv
// -----------------------------------------------------------------------------
// chunked_transfer_sender_fsm
// Stop-and-wait chunked transfer sender with retransmit timer.
//
//   channel | ports                            | dir | word
//   --------+----------------------------------+-----+------------------------
//   event   | req_valid / req_ready / req      | in  | req_t, one event
//   result  | rsp_valid / rsp_ready / rsp      | out | rsp_t, one per event
//   config  | psel penable pwrite paddr pwdata | in  | file_length, timeout
//
// One word per cycle sustained while results are taken; an event passes the
// input register, then the state update into the result register. Synchronous
// reset starts in restart wait with the timer armed to fire on the first
// tick. A stalled result holds in its register while one more event waits in
// the input register; the event channel stalls only when both are full.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module chunked_transfer_sender_fsm
  import cts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_t              rsp
);

  cfg_t cfg;
  req_t req_q;
  logic req_vld;
  logic step;

  cts_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign step      = req_vld && (!rsp_valid || rsp_ready);
  assign req_ready = !req_vld || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_ready) begin
        req_vld <= req_valid;
      end
      if (step) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (req_valid && req_ready) begin
      req_q <= req;
    end
  end

  cts_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (step),
    .req  (req_q),
    .rsp  (rsp)
  );

  `ASSERT_PROP(a_ready_empty, clk, rst, !req_vld |-> req_ready, "not ready while empty")
  `ASSERT_PROP(a_hold_input, clk, rst, (req_vld && !step) |=> req_vld, "held word dropped")
  `ASSERT_PROP(a_hold_result, clk, rst, (rsp_valid && !rsp_ready) |=> rsp_valid, "result dropped")

endmodule

`default_nettype wire

### test/chunked_transfer_sender_fsm_tb.sv
// ----------------------------------------------------------------------------
// chunked_transfer_sender_fsm_tb
// Self-checking bench for the chunked transfer sender. Events go in over a
// valid/ready channel. An in-bench model of the sender state (phase, chunk
// index, announced total, retransmit timer) predicts one result word per
// event. Each result word is checked field by field against that queue.
// The run walks the restart handshake, the timer extremes and the random
// restart and blob phases, and ends in the done state. The file length and
// timeout registers are rewritten between phases over the APB port.
// ----------------------------------------------------------------------------
module chunked_transfer_sender_fsm_tb;
  import cts_pkg::*;

  typedef enum logic [2:0] {
    PH_RESTART_WAIT,
    PH_RESTART_SENT,
    PH_BLOB_SENT,
    PH_DONE
  } tx_phase_t;

  localparam logic [1:0]        REQ_UNUSED    = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_FILE_LEN = {REG_FILE_LEN, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_TIMEOUT  = {REG_TIMEOUT, 2'b00};
  localparam logic [TIMER_W-1:0] TIMEOUT_MAX  = '1;
  localparam int CYCLE_LIMIT = 200_000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              req_valid = 1'b0;
  logic              req_ready;
  req_t              req = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b1;
  rsp_t              rsp;

  chunked_transfer_sender_fsm uut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sender state as seen from outside
  tx_phase_t                tx_phase    = PH_RESTART_WAIT;
  logic [CHUNK_NUM_W-1:0]   next_idx    = '0;
  logic [CHUNK_NUM_W-1:0]   chunk_total = '0;
  logic [TIMER_W-1:0]       timer_left  = '0;
  logic                     timer_on    = 1'b1;
  logic [FILE_LEN_W-1:0]    file_len_q  = FILE_LEN_RST;
  logic [TIMER_W-1:0]       timeout_q   = TIMEOUT_RST;
  logic [FILE_LEN_W-1:0]    blob_file_len;

  rsp_t sends_due[$];
  int   faults = 0;
  int   cycle_count = 0;
  bit   tx_gaps = 1'b1;
  bit   rx_stalls = 1'b1;

  function automatic req_t ev_of(logic [1:0] kind, logic ok, logic rkind, logic acc);
    req_t ev;
    ev.req_type       = kind;
    ev.send_ok        = ok;
    ev.reply_kind     = rkind;
    ev.reply_accepted = acc;
    return ev;
  endfunction

  function automatic req_t random_event(logic favored_kind);
    req_t        ev;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    ev.send_ok        = 1'($urandom_range(0, 1));
    ev.reply_kind     = ($urandom_range(0, 3) == 0) ? ~favored_kind : favored_kind;
    ev.reply_accepted = 1'($urandom_range(0, 1));
    if (roll < 55) ev.req_type = REQ_TICK;
    else if (roll < 85) ev.req_type = REQ_REPLY;
    else if (roll < 95) ev.req_type = REQ_SENT;
    else ev.req_type = REQ_UNUSED;
    return ev;
  endfunction

  task automatic send_chunk(inout rsp_t word);
    logic [CHUNK_NUM_W+CHUNK_SHIFT-1:0] offset;
    logic [CHUNK_NUM_W+CHUNK_SHIFT-1:0] left;
    offset = {next_idx, {CHUNK_SHIFT{1'b0}}};
    left = (offset < file_len_q) ? file_len_q - offset : '0;
    word.send_kind    = SEND_BLOB;
    word.chunk_number = next_idx;
    word.chunk_bytes  = (left > CHUNK_BYTES) ? CHUNK_BYTES : left[CHUNK_BYTES_W-1:0];
    timer_left = timeout_q;
    timer_on   = 1'b1;
    tx_phase   = PH_BLOB_SENT;
  endtask

  task automatic step_sender(input req_t ev);
    rsp_t word;
    word = '0;
    if (tx_phase != PH_DONE) begin
      case (ev.req_type)
        REQ_TICK: begin
          if (timer_on) begin
            if (timer_left <= 1) begin
              timer_on   = 1'b0;
              timer_left = '0;
              if (tx_phase == PH_BLOB_SENT) begin
                send_chunk(word);
              end else begin
                chunk_total = (file_len_q == '0) ? '0 :
                              CHUNK_NUM_W'((file_len_q >> CHUNK_SHIFT) + 1);
                timer_left = timeout_q;
                timer_on   = 1'b1;
                tx_phase   = PH_RESTART_SENT;
                word.send_kind = SEND_RESTART;
              end
            end else begin
              timer_left = timer_left - 1'b1;
            end
          end
        end
        REQ_REPLY: begin
          if (tx_phase == PH_RESTART_SENT && ev.reply_kind == REPLY_RESTART) begin
            if (ev.reply_accepted) begin
              send_chunk(word);
            end else begin
              tx_phase   = PH_RESTART_WAIT;
              timer_left = timeout_q;
              timer_on   = 1'b1;
            end
          end else if (tx_phase == PH_BLOB_SENT && ev.reply_kind == REPLY_BLOB) begin
            next_idx = next_idx + 1'b1;
            if (next_idx < chunk_total) begin
              send_chunk(word);
            end else begin
              tx_phase   = PH_DONE;
              timer_on   = 1'b0;
              timer_left = '0;
            end
          end
        end
        default: ;
      endcase
    end
    word.chunk_count   = chunk_total;
    word.transfer_done = (tx_phase == PH_DONE);
    sends_due.push_back(word);
  endtask

  task automatic send_event(input req_t ev);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req       <= ev;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    step_sender(ev);
  endtask

  // drop valid and wait until every result word is back
  task automatic settle();
    req_valid <= 1'b0;
    while (sends_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_FILE_LEN) file_len_q = value;
    else timeout_q = value[TIMER_W-1:0];
    @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_event(ev_of(REQ_SENT, 1'b0, 1'b0, 1'b0));
    send_event(ev_of(REQ_SENT, 1'b1, 1'b1, 1'b1));
    send_event(ev_of(REQ_UNUSED, 1'b1, 1'b0, 1'b1));
    send_event(ev_of(REQ_REPLY, 1'b0, REPLY_RESTART, 1'b1));
    send_event(ev_of(REQ_REPLY, 1'b1, REPLY_BLOB, 1'b0));
    send_event(ev_of(REQ_TICK, 1'b0, 1'b0, 1'b0));
    settle();
  endtask

  task automatic test_restart_handshake();
    logic [FILE_LEN_W-1:0] lengths[4];
    lengths = '{32'd0, 32'd4095, 32'd4096, 32'hFFFF_FFFF};
    send_event(ev_of(REQ_REPLY, 1'b0, REPLY_BLOB, 1'b1));
    send_event(ev_of(REQ_SENT, 1'b1, 1'b0, 1'b0));
    send_event(ev_of(REQ_TICK, 1'b1, 1'b1, 1'b1));
    settle();
    write_reg(ADDR_TIMEOUT, 32'd1);
    send_event(ev_of(REQ_REPLY, 1'b0, REPLY_RESTART, 1'b0));
    send_event(ev_of(REQ_TICK, 1'b0, 1'b0, 1'b0));
    foreach (lengths[i]) begin
      settle();
      write_reg(ADDR_FILE_LEN, lengths[i]);
      send_event(ev_of(REQ_REPLY, 1'b1, REPLY_RESTART, 1'b0));
      send_event(ev_of(REQ_TICK, 1'b0, 1'b1, 1'b0));
    end
    send_event(ev_of(REQ_TICK, 1'b1, 1'b0, 1'b1));
    settle();
  endtask

  // fire once to arm the timer at its top value, then count down from there
  task automatic test_long_timeout();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    write_reg(ADDR_TIMEOUT, DATA_W'(TIMEOUT_MAX));
    send_event(ev_of(REQ_TICK, 1'b0, 1'b0, 1'b0));
    repeat (64)
      send_event(ev_of(REQ_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1))));
    settle();
    write_reg(ADDR_TIMEOUT, 32'd3);
    send_event(ev_of(REQ_REPLY, 1'b1, REPLY_RESTART, 1'b0));
    settle();
  endtask

  task automatic test_restart_random();
    req_t ev;
    repeat (5) begin
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 4))
        0: write_reg(ADDR_FILE_LEN, '0);
        1: write_reg(ADDR_FILE_LEN, '1);
        2: write_reg(ADDR_FILE_LEN, $urandom);
        3: write_reg(ADDR_FILE_LEN, $urandom_range(1, 20000));
        default: write_reg(ADDR_FILE_LEN, DATA_W'({$urandom_range(0, 1023), 12'd0}));
      endcase
      write_reg(ADDR_TIMEOUT, $urandom_range(1, 6));
      repeat (30) begin
        ev = random_event(REPLY_RESTART);
        // hold the restart phase: no positive restart reply yet
        if (ev.req_type == REQ_REPLY && ev.reply_kind == REPLY_RESTART &&
            tx_phase == PH_RESTART_SENT)
          ev.reply_accepted = 1'b0;
        send_event(ev);
      end
      settle();
    end
  endtask

  task automatic test_blob_entry();
    blob_file_len = FILE_LEN_W'({$urandom_range(70, 100), 12'd0} + $urandom_range(1, 4095));
    write_reg(ADDR_FILE_LEN, blob_file_len);
    write_reg(ADDR_TIMEOUT, 32'd4);
    if (tx_phase == PH_RESTART_SENT)
      send_event(ev_of(REQ_REPLY, 1'b0, REPLY_RESTART, 1'b0));
    while (tx_phase != PH_RESTART_SENT)
      send_event(ev_of(REQ_TICK, 1'b0, 1'b0, 1'b0));
    send_event(ev_of(REQ_REPLY, 1'b1, REPLY_BLOB, 1'b1));
    send_event(ev_of(REQ_REPLY, 1'b0, REPLY_RESTART, 1'b1));
    send_event(ev_of(REQ_REPLY, 1'b1, REPLY_RESTART, 1'b0));
    send_event(ev_of(REQ_REPLY, 1'b1, REPLY_RESTART, 1'b1));
    repeat (4) send_event(ev_of(REQ_TICK, 1'b1, 1'b0, 1'b1));
    settle();
  endtask

  task automatic test_blob_random();
    req_t ev;
    repeat (7) begin
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 4))
        0: write_reg(ADDR_FILE_LEN, '0);
        1: write_reg(ADDR_FILE_LEN, '1);
        2: write_reg(ADDR_FILE_LEN, $urandom);
        3: write_reg(ADDR_FILE_LEN,
                     FILE_LEN_W'({next_idx, 12'd0} + $urandom_range(0, 8191)));
        default: write_reg(ADDR_FILE_LEN, blob_file_len);
      endcase
      write_reg(ADDR_TIMEOUT, $urandom_range(1, 8));
      repeat (40) begin
        ev = random_event(REPLY_BLOB);
        // keep the last chunk for the closing test
        if (ev.req_type == REQ_REPLY && ev.reply_kind == REPLY_BLOB &&
            next_idx + 1 >= chunk_total)
          ev.reply_kind = REPLY_RESTART;
        send_event(ev);
      end
      settle();
    end
  endtask

  task automatic test_finish_and_done();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    write_reg(ADDR_FILE_LEN, blob_file_len);
    while (tx_phase != PH_DONE)
      send_event(ev_of(REQ_REPLY, 1'($urandom_range(0, 1)), REPLY_BLOB,
                       1'($urandom_range(0, 1))));
    send_event(ev_of(REQ_TICK, 1'b0, 1'b0, 1'b0));
    send_event(ev_of(REQ_SENT, 1'b1, 1'b1, 1'b0));
    send_event(ev_of(REQ_UNUSED, 1'b0, 1'b1, 1'b1));
    send_event(ev_of(REQ_REPLY, 1'b0, REPLY_BLOB, 1'b1));
    send_event(ev_of(REQ_REPLY, 1'b1, REPLY_RESTART, 1'b1));
    settle();
    write_reg(ADDR_TIMEOUT, 32'd1);
    write_reg(ADDR_FILE_LEN, 32'd5);
    repeat (3) send_event(ev_of(REQ_TICK, 1'b1, 1'b1, 1'b0));
    send_event(ev_of(REQ_REPLY, 1'b0, REPLY_RESTART, 1'b0));
    settle();
  endtask

  always begin
    @(posedge clk);
    if (rx_stalls && $urandom_range(0, 7) == 0) begin
      rsp_ready <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    rsp_ready <= 1'b1;
  end

  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (sends_due.size() == 0) begin
        faults++;
        if (faults <= 10) $display("unexpected result word: %p", rsp);
      end else begin
        want = sends_due.pop_front();
        if (rsp.send_kind !== want.send_kind || rsp.chunk_number !== want.chunk_number ||
            rsp.chunk_bytes !== want.chunk_bytes || rsp.chunk_count !== want.chunk_count ||
            rsp.transfer_done !== want.transfer_done) begin
          faults++;
          if (faults <= 10)
            $display("mismatch: expected kind=%0d num=%0d bytes=%0d count=%0d done=%0d, %s",
                     want.send_kind, want.chunk_number, want.chunk_bytes,
                     want.chunk_count, want.transfer_done,
                     $sformatf("got kind=%0d num=%0d bytes=%0d count=%0d done=%0d",
                               rsp.send_kind, rsp.chunk_number, rsp.chunk_bytes,
                               rsp.chunk_count, rsp.transfer_done));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_restart_handshake();
    test_long_timeout();
    test_restart_random();
    test_blob_entry();
    test_blob_random();
    test_finish_and_done();
    repeat (8) @(posedge clk);
    if (faults == 0 && sends_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
